[hdl/bitmap_inode_block_allocator_macros.svh]
// Assertion helpers used by the allocator top module.
`ifndef BITMAP_INODE_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_INODE_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bia_pkg.sv]
package bia_pkg;

    localparam int INODE_COUNT_DEF = 32;
    localparam int BLOCK_COUNT_DEF = 256;

    // Bitmap bits held by one cell of the chain.
    localparam int SEG_W = 4;
    localparam int SEG   = 1 << SEG_W;

    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int ID_W    = INDEX_W - SEG_W;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } status_t;

    // A request as it walks down the chain of cells.
    typedef struct packed {
        logic                active;
        logic                kind;
        logic                pool;
        logic [INDEX_W-1:0]  index;
        logic                done;
        status_t             status;
        logic [INDEX_W-1:0]  granted;
    } token_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  granted;
        logic [COUNT_W-1:0]  used_count;
    } result_t;

    // Bits of a cell's segment that exist in a pool of the given size.
    function automatic logic [SEG-1:0] seg_mask(input int cell_id, input int count);
        logic [SEG-1:0] m;
        m = '0;
        for (int b = 0; b < SEG; b++) begin
            m[b] = ((cell_id * SEG) + b) < count;
        end
        return m;
    endfunction

endpackage

[hdl/bia_cell.sv]
module bia_cell #(
    parameter int CELL_ID     = 0,
    parameter int INODE_COUNT = bia_pkg::INODE_COUNT_DEF,
    parameter int BLOCK_COUNT = bia_pkg::BLOCK_COUNT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  bia_pkg::token_t tok_i,
    output bia_pkg::token_t tok_o
);
    import bia_pkg::*;

    localparam logic [SEG-1:0]  IMASK = seg_mask(CELL_ID, INODE_COUNT);
    localparam logic [SEG-1:0]  BMASK = seg_mask(CELL_ID, BLOCK_COUNT);
    localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_ID);

    logic [SEG-1:0]   imap_reg, imap_next;
    logic [SEG-1:0]   bmap_reg, bmap_next;
    token_t           tok_reg, tok_next;
    logic [SEG-1:0]   cur_map;
    logic [SEG-1:0]   avail;
    logic [SEG_W-1:0] pos;
    logic [SEG_W-1:0] bit_sel;
    logic             hit;

    assign cur_map = (tok_i.pool == POOL_BLOCK) ? bmap_reg : imap_reg;
    assign avail   = ~cur_map & ((tok_i.pool == POOL_BLOCK) ? BMASK : IMASK);
    assign bit_sel = tok_i.index[SEG_W-1:0];
    assign hit     = (tok_i.index[INDEX_W-1:SEG_W] == MY_ID);

    // Lowest free bit of this segment.
    always_comb begin
        pos = '0;
        for (int b = SEG - 1; b >= 0; b--) begin
            if (avail[b]) begin
                pos = SEG_W'(b);
            end
        end
    end

    always_comb begin
        logic [SEG-1:0] upd;
        upd       = cur_map;
        imap_next = imap_reg;
        bmap_next = bmap_reg;
        tok_next  = tok_i;
        if (tok_i.active && !tok_i.done) begin
            if (tok_i.kind == KIND_ALLOC) begin
                if (|avail) begin
                    upd[pos]         = 1'b1;
                    tok_next.done    = 1'b1;
                    tok_next.status  = ST_OK;
                    tok_next.granted = {MY_ID, pos};
                end
            end else if (hit) begin
                tok_next.done = 1'b1;
                if (cur_map[bit_sel]) begin
                    upd[bit_sel]    = 1'b0;
                    tok_next.status = ST_OK;
                end else begin
                    tok_next.status = ST_FREE;
                end
            end
            if (tok_i.pool == POOL_BLOCK) begin
                bmap_next = upd;
            end else begin
                imap_next = upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imap_reg <= '0;
            bmap_reg <= '0;
            tok_reg  <= '0;
        end else begin
            imap_reg <= imap_next;
            bmap_reg <= bmap_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

[hdl/bitmap_inode_block_allocator.sv]
// Channel | Direction | tvalid/tready     | tdata                          | tuser
// s_      | in        | s_tvalid/s_tready | index[7:0]                     | kind[0], pool[1]
// m_      | out       | m_tvalid/m_tready | granted[7:0], used_count[16:8] | status[1:0]
//
// A request walks one cell per cycle down a chain of ceil(max(pools)/16) cells, each holding
// 16 bits of both bitmaps; the result leaving the last cell is registered in the output or holding register.
// Requests are taken one at a time.
// Reset (synchronous, aresetn low) clears both bitmaps and counts at once; no sweep follows.
// A finished result waiting on m_tready stays in the output register and the next request is
// still accepted; a later result that finds the output register full is parked in a holding
// register. Input stalls while in reset, while a request is in the chain or the holding
// register is full.
module bitmap_inode_block_allocator #(
    parameter int INODE_COUNT = bia_pkg::INODE_COUNT_DEF,
    parameter int BLOCK_COUNT = bia_pkg::BLOCK_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bia_pkg::S_TDATA_W-1:0]   s_tdata,   // index[7:0]
    input  logic [bia_pkg::S_TUSER_W-1:0]   s_tuser,   // kind[0], pool[1]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bia_pkg::M_TDATA_W-1:0]   m_tdata,   // granted[7:0], used_count[16:8], zero
    output logic [bia_pkg::M_TUSER_W-1:0]   m_tuser    // status[1:0]
);
    import bia_pkg::*;

    `include "bitmap_inode_block_allocator_macros.svh"

    localparam int MAX_COUNT = (INODE_COUNT > BLOCK_COUNT) ? INODE_COUNT : BLOCK_COUNT;
    localparam int NCELL     = (MAX_COUNT + SEG - 1) / SEG;
    localparam int IU_W      = $clog2(INODE_COUNT + 1);
    localparam int BU_W      = $clog2(BLOCK_COUNT + 1);

    token_t           chain [NCELL+1];
    token_t           entry;
    token_t           tail;
    logic             accept;
    logic             out_free;
    logic             range_err;
    logic             busy_reg, busy_next;
    logic             hold_valid_reg, hold_valid_next;
    result_t          hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next;
    result_t          out_reg, out_next;
    result_t          res;
    logic [IU_W-1:0]  inode_used_reg, inode_used_next;
    logic [BU_W-1:0]  block_used_reg, block_used_next;

    assign s_tready = aresetn && !busy_reg && !hold_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Range check is done once at entry; a rejected free rides the chain already done.
    always_comb begin
        if (s_tuser[1] == POOL_BLOCK) begin
            range_err = {1'b0, s_tdata} >= (INDEX_W + 1)'(BLOCK_COUNT);
        end else begin
            range_err = {1'b0, s_tdata} >= (INDEX_W + 1)'(INODE_COUNT);
        end
        entry.active  = accept;
        entry.kind    = s_tuser[0];
        entry.pool    = s_tuser[1];
        entry.index   = s_tdata;
        entry.done    = (s_tuser[0] == KIND_FREE) && range_err;
        entry.status  = ((s_tuser[0] == KIND_FREE) && range_err) ? ST_RANGE : ST_FULL;
        entry.granted = '0;
    end

    assign chain[0] = entry;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        bia_cell #(
            .CELL_ID     (g),
            .INODE_COUNT (INODE_COUNT),
            .BLOCK_COUNT (BLOCK_COUNT)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (chain[g]),
            .tok_o   (chain[g+1])
        );
    end

    assign tail = chain[NCELL];

    // Counts are settled as the request leaves the last cell.
    always_comb begin
        inode_used_next = inode_used_reg;
        block_used_next = block_used_reg;
        if (tail.active && tail.status == ST_OK) begin
            if (tail.pool == POOL_BLOCK) begin
                if (tail.kind == KIND_ALLOC) begin
                    block_used_next = block_used_reg + BU_W'(1);
                end else begin
                    block_used_next = block_used_reg - BU_W'(1);
                end
            end else begin
                if (tail.kind == KIND_ALLOC) begin
                    inode_used_next = inode_used_reg + IU_W'(1);
                end else begin
                    inode_used_next = inode_used_reg - IU_W'(1);
                end
            end
        end
        res.status     = tail.status;
        res.granted    = tail.granted;
        res.used_count = (tail.pool == POOL_BLOCK) ? COUNT_W'(block_used_next)
                                                   : COUNT_W'(inode_used_next);
    end

    always_comb begin
        busy_next       = busy_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        if (accept) begin
            busy_next = 1'b1;
        end
        if (tail.active) begin
            busy_next = 1'b0;
        end
        if (out_free) begin
            if (hold_valid_reg) begin
                m_valid_next    = 1'b1;
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end else if (tail.active) begin
                m_valid_next = 1'b1;
                out_next     = res;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (tail.active) begin
            hold_valid_next = 1'b1;
            hold_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            inode_used_reg <= '0;
            block_used_reg <= '0;
        end else begin
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            inode_used_reg <= inode_used_next;
            block_used_reg <= block_used_next;
        end
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{(M_TDATA_W - INDEX_W - COUNT_W){1'b0}},
                       out_reg.used_count, out_reg.granted};

    `BIA_ASSERT_SAME(a_tail_busy, aclk, aresetn, tail.active, busy_reg,
        "request left the chain without being in flight")
    `BIA_ASSERT_SAME(a_hold_out, aclk, aresetn, hold_valid_reg, m_valid_reg,
        "holding register full while output register empty")
    `BIA_ASSERT_NEXT(a_hold_fill, aclk, aresetn, tail.active && !out_free,
        hold_valid_reg, "result lost while output stalled")
    `BIA_ASSERT_SAME(a_granted_zero, aclk, aresetn,
        tail.active && (tail.status != ST_OK || tail.kind == KIND_FREE),
        tail.granted == '0, "nonzero grant without a successful allocation")
    `BIA_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1,
        inode_used_reg <= IU_W'(INODE_COUNT) && block_used_reg <= BU_W'(BLOCK_COUNT),
        "used count exceeds pool size")

endmodule

[test/bitmap_inode_block_allocator_test.sv]
`timescale 1ns / 100ps

module bitmap_inode_block_allocator_test;
    import bia_pkg::*;

    localparam int INODE_SIZE = INODE_COUNT_DEF;
    localparam int BLOCK_SIZE = BLOCK_COUNT_DEF;
    localparam int MAP_W      = 1 << INDEX_W;
    // The chain has one cell per 16 bitmap bits plus the output register.
    localparam int CHAIN_LAT  = ((BLOCK_SIZE > INODE_SIZE ? BLOCK_SIZE : INODE_SIZE) + SEG - 1)
                                / SEG + 1;

    // Tracks both bitmaps and the results still owed by the allocator.
    class alloc_scoreboard;
        bit [MAP_W-1:0] map [2];
        int unsigned    used [2];
        result_t        pending [$];
        int             errors;
        int             requests;
        int             status_hits [4];
        int             full_hits [2];

        function int pool_size(bit pool);
            return (pool == POOL_BLOCK) ? BLOCK_SIZE : INODE_SIZE;
        endfunction

        // Returns a random entry that is in use, or -1 if the pool is empty.
        function int used_entry(bit pool);
            int size;
            int start;
            int idx;
            size  = pool_size(pool);
            start = $urandom_range(0, size - 1);
            for (int k = 0; k < size; k++) begin
                idx = (start + k) % size;
                if (map[pool][idx]) begin
                    return idx;
                end
            end
            return -1;
        endfunction

        function void note_request(bit kind, bit pool, bit [INDEX_W-1:0] index);
            result_t r;
            int      size;
            size      = pool_size(pool);
            r.status  = ST_OK;
            r.granted = '0;
            if (kind == KIND_ALLOC) begin
                r.status = ST_FULL;
                for (int i = 0; i < size; i++) begin
                    if (!map[pool][i]) begin
                        map[pool][i] = 1'b1;
                        used[pool]++;
                        r.granted = i[INDEX_W-1:0];
                        r.status  = ST_OK;
                        break;
                    end
                end
                if (r.status == ST_FULL) begin
                    full_hits[pool]++;
                end
            end else if (index >= size) begin
                r.status = ST_RANGE;
            end else if (!map[pool][index]) begin
                r.status = ST_FREE;
            end else begin
                map[pool][index] = 1'b0;
                if (used[pool] > 0) begin
                    used[pool]--;
                end
            end
            r.used_count = used[pool][COUNT_W-1:0];
            pending.push_back(r);
            requests++;
            status_hits[r.status]++;
        endfunction

        function void check_result(logic [1:0] status, logic [INDEX_W-1:0] granted,
                                   logic [COUNT_W-1:0] used_count);
            result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result: status %0d granted %0d used_count %0d",
                         $time, status, granted, used_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (granted !== want.granted) begin
                $display("%0t: granted mismatch: expected %0d, actual %0d",
                         $time, want.granted, granted);
                errors++;
            end
            if (used_count !== want.used_count) begin
                $display("%0t: used_count mismatch: expected %0d, actual %0d",
                         $time, want.used_count, used_count);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    alloc_scoreboard ledger = new();
    // When set, neither side inserts idle cycles.
    bit steady;

    bitmap_inode_block_allocator #(
        .INODE_COUNT(INODE_SIZE),
        .BLOCK_COUNT(BLOCK_SIZE)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input bit kind, input bit pool, input bit [INDEX_W-1:0] index);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= index;
        s_tuser  <= {pool, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.note_request(kind, pool, index);
    endtask

    task automatic random_request(input int alloc_pct, input int block_pct);
        bit                 kind;
        bit                 pool;
        bit [INDEX_W-1:0]   index;
        int                 roll;
        int                 pick;
        kind  = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
        pool  = ($urandom_range(0, 99) < block_pct) ? POOL_BLOCK : POOL_INODE;
        index = INDEX_W'($urandom_range(0, MAP_W - 1));
        if (kind == KIND_FREE) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                pick = ledger.used_entry(pool);
                if (pick >= 0) begin
                    index = pick[INDEX_W-1:0];
                end
            end else if (roll < 85) begin
                index = INDEX_W'($urandom_range(0, ledger.pool_size(pool) - 1));
            end
        end
        send_request(kind, pool, index);
    endtask

    // Lowers the request and waits until every outstanding result is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_result(m_tuser[1:0], m_tdata[INDEX_W-1:0],
                                m_tdata[INDEX_W+COUNT_W-1:INDEX_W]);
        end
    end

    initial begin
        int churn_alloc [5] = '{20, 50, 80, 30, 60};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        steady   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests: index ignored on allocate, range edges, double frees,
        // reuse of the lowest entry and a free on an empty pool.
        send_request(KIND_ALLOC, POOL_INODE, 8'hFF);
        send_request(KIND_ALLOC, POOL_BLOCK, 8'h00);
        send_request(KIND_ALLOC, POOL_BLOCK, 8'hA5);
        send_request(KIND_FREE,  POOL_INODE, 8'd0);
        send_request(KIND_FREE,  POOL_INODE, 8'd0);
        send_request(KIND_FREE,  POOL_INODE, INODE_SIZE[INDEX_W-1:0]);
        send_request(KIND_FREE,  POOL_INODE, 8'hFF);
        send_request(KIND_FREE,  POOL_INODE, INODE_SIZE[INDEX_W-1:0] - 8'd1);
        send_request(KIND_FREE,  POOL_BLOCK, 8'hFF);
        send_request(KIND_FREE,  POOL_BLOCK, 8'd0);
        send_request(KIND_ALLOC, POOL_BLOCK, 8'h5A);
        send_request(KIND_FREE,  POOL_BLOCK, 8'd1);
        send_request(KIND_FREE,  POOL_BLOCK, 8'd0);
        send_request(KIND_FREE,  POOL_BLOCK, 8'd0);
        send_request(KIND_ALLOC, POOL_INODE, 8'h00);
        drain_results();

        // Fill the inode pool past capacity, then the block pool.
        for (int n = 0; n < 45; n++) random_request(90, 0);
        drain_results();
        steady = 1'b1;
        for (int n = 0; n < 40; n++) random_request(95, 100);
        steady = 1'b0;
        for (int n = 0; n < 260; n++) random_request(95, 100);
        drain_results();

        // Mixed traffic with a changing balance of allocations and frees.
        for (int seg = 0; seg < 5; seg++) begin
            steady = (seg == 2);
            for (int n = 0; n < 100; n++) random_request(churn_alloc[seg], 50);
            if (seg == 1) begin
                drain_results();
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (CHAIN_LAT * 2 + 10) @(posedge aclk);
        $display("Sent %0d requests: %0d ok, %0d full, %0d out of range, %0d already free.",
                 ledger.requests, ledger.status_hits[ST_OK], ledger.status_hits[ST_FULL],
                 ledger.status_hits[ST_RANGE], ledger.status_hits[ST_FREE]);
        $display("Allocate on a full pool was seen %0d times for inodes, %0d for blocks.",
                 ledger.full_hits[POOL_INODE], ledger.full_hits[POOL_BLOCK]);
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", ledger.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
